[hdl/abd_pkg.sv]
`default_nettype none

package abd_pkg;

  // Widths of the stream fields.
  localparam int BYTE_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 8;
  localparam int FILT_W   = 3;
  localparam int SHIFT_W  = 4;
  localparam int POS_W    = 7;

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DATA_BYTES = 8'd0,
    REG_STEREO     = 8'd1
  } abd_reg_t;

  // Headers with a filter nibble at or above this value mark the block as unusable.
  localparam logic [3:0] FILTER_COUNT = 4'd5;

  // Data bytes per block after reset.
  localparam logic [POS_W-1:0] DATA_BYTES_RESET = 7'd16;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic load_byte;
    logic load_header;
    logic header_bad;
    logic compute;
    logic nib_hi;
    logic channel;
  } abd_cmd_t;

  // Predictor weight applied to the most recent sample.
  function automatic logic signed [COEF_W-1:0] coef_recent(input logic [FILT_W-1:0] f);
    logic signed [COEF_W-1:0] c;
    unique case (f)
      3'd1:    c = 8'sh3C;
      3'd2:    c = 8'sh73;
      3'd3:    c = 8'sh62;
      3'd4:    c = 8'sh7A;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Predictor weight applied to the older sample.
  function automatic logic signed [COEF_W-1:0] coef_older(input logic [FILT_W-1:0] f);
    logic signed [COEF_W-1:0] c;
    unique case (f)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/abd_ifs.sv]
`default_nettype none

// Encoded byte stream channel.
interface abd_byte_if
  import abd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] encoded_byte;

  modport source (output valid, output encoded_byte, input ready);
  modport sink (input valid, input encoded_byte, output ready);
endinterface

// Decoded sample channel.
interface abd_sample_if
  import abd_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       channel;
  logic                       last;

  modport source (output valid, output sample, output channel, output last, input ready);
  modport sink (input valid, input sample, input channel, input last, output ready);
endinterface

// Register write channel.
interface abd_cfg_if
  import abd_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/abd_ctrl.sv]
`default_nettype none

module abd_ctrl
  import abd_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [3:0]      in_filter,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  input  wire logic            cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                 cfg_ready,
  output abd_cmd_t             cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NIB0,
    S_NIB1
  } state_t;

  state_t           state;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] data_bytes;
  logic             stereo;
  logic             current_channel;
  logic             byte_channel;
  logic             block_invalid;

  logic             slot_free;
  logic             in_xfer;
  logic             is_header;
  logic             header_bad;
  logic             channel_after;
  logic             compute;

  // The output register can be refilled when empty or when its sample leaves this cycle.
  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) || ((state == S_NIB1) && slot_free);
  assign in_xfer    = in_valid && in_ready;
  assign is_header  = (byte_position == '0);
  assign header_bad = (in_filter >= FILTER_COUNT);
  assign compute    = ((state == S_NIB0) || (state == S_NIB1)) && slot_free;
  assign cfg_ready  = 1'b1;

  // Channel that the next block uses once this one ends.
  assign channel_after = (stereo && (CHANNELS > 1)) ? !current_channel : 1'b0;

  // Commands to the datapath.
  always_comb begin
    cmd.load_byte   = in_xfer;
    cmd.load_header = in_xfer && is_header;
    cmd.header_bad  = header_bad;
    cmd.compute     = compute;
    cmd.nib_hi      = (state == S_NIB1);
    cmd.channel     = byte_channel;
  end

  // Sequencer, block position tracking and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      byte_position   <= '0;
      data_bytes      <= DATA_BYTES_RESET;
      stereo          <= 1'b0;
      current_channel <= 1'b0;
      byte_channel    <= 1'b0;
      block_invalid   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      // Output register occupancy.
      if (compute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Nibble sequencing.
      if (state == S_NIB0 && slot_free) begin
        state <= S_NIB1;
      end else if (state == S_NIB1 && slot_free) begin
        state <= S_IDLE;
      end

      // A byte transfer decides whether its two nibbles are decoded into samples.
      if (in_xfer) begin
        if (is_header) begin
          block_invalid <= header_bad;
          state         <= S_IDLE;
          if (data_bytes == '0) begin
            byte_position   <= '0;
            current_channel <= channel_after;
          end else begin
            byte_position <= POS_W'(1);
          end
        end else begin
          byte_channel <= (CHANNELS > 1) ? current_channel : 1'b0;
          state        <= block_invalid ? S_IDLE : S_NIB0;
          if (byte_position >= data_bytes) begin
            byte_position   <= '0;
            current_channel <= channel_after;
          end else begin
            byte_position <= byte_position + POS_W'(1);
          end
        end
      end

      // Register writes; unknown indexes are dropped.
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DATA_BYTES: data_bytes <= cfg_data[POS_W-1:0];
          REG_STEREO:     stereo     <= cfg_data[0];
          default:        ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hdl/abd_datapath.sv]
`default_nettype none

module abd_datapath
  import abd_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [BYTE_W-1:0] encoded_byte,
  input  wire abd_cmd_t          cmd,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                   channel,
  output logic                   last
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [BYTE_W-1:0]          byte_q;
  logic [FILT_W-1:0]          filter_select;
  logic [SHIFT_W-1:0]         shift_amount;
  logic signed [SAMPLE_W-1:0] history_recent [CHANNELS];
  logic signed [SAMPLE_W-1:0] history_older  [CHANNELS];

  logic [CH_W-1:0]               ch_idx;
  logic [3:0]                    nibble;
  logic signed [SAMPLE_W-1:0]    nib_scaled_in;
  logic signed [SAMPLE_W-1:0]    scaled;
  logic signed [SAMPLE_W-1:0]    prev1;
  logic signed [SAMPLE_W-1:0]    prev2;
  logic signed [SAMPLE_W+COEF_W-1:0] prod_recent;
  logic signed [SAMPLE_W+COEF_W-1:0] prod_older;
  logic [SAMPLE_W+COEF_W:0]      feedback;
  logic [SAMPLE_W-1:0]           sample_next;

  assign ch_idx = CH_W'(cmd.channel);

  // Nibble scaling: sign-extended nibble in the top bits, then an arithmetic shift right.
  assign nibble        = cmd.nib_hi ? byte_q[7:4] : byte_q[3:0];
  assign nib_scaled_in = {nibble, 12'b0};
  assign scaled        = nib_scaled_in >>> shift_amount;

  // Two-tap prediction from this channel's history.
  assign prev1       = history_recent[ch_idx];
  assign prev2       = history_older[ch_idx];
  assign prod_recent = prev1 * coef_recent(filter_select);
  assign prod_older  = prev2 * coef_older(filter_select);
  assign feedback    = {prod_recent[SAMPLE_W+COEF_W-1], prod_recent}
                     + {prod_older[SAMPLE_W+COEF_W-1], prod_older};

  // Only the low sixteen bits survive the wrap, so the shifted feedback is a bit slice.
  assign sample_next = scaled + feedback[SAMPLE_W+5:6];

  // Latched byte and header fields.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_q <= encoded_byte;
    end
    if (cmd.load_header) begin
      filter_select <= cmd.header_bad ? '0 : encoded_byte[FILT_W+3:4];
      shift_amount  <= encoded_byte[SHIFT_W-1:0];
    end
  end

  // Per-channel history; it moves on by one sample per decoded nibble.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        history_recent[i] <= '0;
        history_older[i]  <= '0;
      end
    end else if (cmd.compute) begin
      history_older[ch_idx]  <= prev1;
      history_recent[ch_idx] <= sample_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.compute) begin
      sample  <= sample_next;
      channel <= cmd.channel;
      last    <= cmd.nib_hi;
    end
  end

endmodule

`default_nettype wire

[hdl/adpcm_block_decoder_core.sv]
// A usable block's data byte yields samples in S_NIB0 (low nibble), then S_NIB1 (high),
// each into the output register; output back-pressure holds either state. A header
// byte returns to S_IDLE. New bytes are taken in S_IDLE, or in S_NIB1 once the output
// slot is free: each sample needs the single predictor multiply-add on prior history.
// Reset (synchronous, active high) clears history, block position, channel and
// configuration (16 data bytes per block, mono).
`default_nettype none

module adpcm_block_decoder_core
  import abd_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  abd_byte_if.sink     byte_in,
  abd_sample_if.source sample_out,
  abd_cfg_if.sink      cfg
);

  abd_cmd_t cmd;

  // Block sequencing, handshakes and registers.
  abd_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_in.valid),
    .in_filter (byte_in.encoded_byte[7:4]),
    .in_ready  (byte_in.ready),
    .out_ready (sample_out.ready),
    .out_valid (sample_out.valid),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cfg_ready (cfg.ready),
    .cmd       (cmd)
  );

  // Sample reconstruction and history.
  abd_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .encoded_byte (byte_in.encoded_byte),
    .cmd          (cmd),
    .sample       (sample_out.sample),
    .channel      (sample_out.channel),
    .last         (sample_out.last)
  );

endmodule

`default_nettype wire
